### rtl/attc_pkg.sv
// Shared types, codes and tables of the ANSI text terminal controller.
package attc_pkg;

   // stream bytes
   localparam logic [7:0] ESC_CODE    = 8'h1B;
   localparam logic [7:0] LBR_CODE    = 8'h5B;
   localparam logic [7:0] SEMI_CODE   = 8'h3B;
   localparam logic [7:0] DIGIT0_CODE = 8'h30;
   localparam logic [7:0] DIGIT9_CODE = 8'h39;
   localparam logic [7:0] SGR_FINAL   = 8'h6D;
   localparam logic [7:0] ED_FINAL    = 8'h4A;
   localparam logic [7:0] CUP_FINAL   = 8'h48;
   localparam logic [7:0] LF_CODE     = 8'h0A;
   localparam logic [7:0] CR_CODE     = 8'h0D;
   localparam logic [7:0] TAB_CODE    = 8'h09;
   localparam logic [7:0] BS_CODE     = 8'h08;

   localparam logic [8:0] TAB_STEP = 9'd4;
   localparam logic [8:0] TAB_MASK = 9'h1FC;

   // SGR codes
   localparam logic [31:0] SGR_RESET          = 32'd0;
   localparam logic [31:0] SGR_BOLD           = 32'd1;
   localparam logic [31:0] SGR_NORMAL         = 32'd22;
   localparam logic [31:0] SGR_FG_FIRST       = 32'd30;
   localparam logic [31:0] SGR_FG_LAST        = 32'd37;
   localparam logic [31:0] SGR_FG_DEFAULT     = 32'd39;
   localparam logic [31:0] SGR_BG_FIRST       = 32'd40;
   localparam logic [31:0] SGR_BG_LAST        = 32'd47;
   localparam logic [31:0] SGR_BG_DEFAULT     = 32'd49;
   localparam logic [31:0] SGR_FG_BRIGHT_FIRST = 32'd90;
   localparam logic [31:0] SGR_FG_BRIGHT_LAST  = 32'd97;
   localparam logic [31:0] SGR_BG_BRIGHT_FIRST = 32'd100;
   localparam logic [31:0] SGR_BG_BRIGHT_LAST  = 32'd107;

   // erase-display arguments that clear
   localparam logic [31:0] ED_TO_END = 32'd0;
   localparam logic [31:0] ED_ALL    = 32'd2;

   // register indexes
   localparam logic CSR_TEXT_COLUMNS = 1'b0;
   localparam logic CSR_TEXT_ROWS    = 1'b1;

   localparam logic [7:0] COLS_RESET = 8'd80;
   localparam logic [6:0] ROWS_RESET = 7'd25;
   localparam logic [3:0] FORE_RESET = 4'd7;
   localparam logic [3:0] BACK_RESET = 4'd0;

   localparam logic [3:0] BASE_MAP [8] = '{4'd0, 4'd4, 4'd2, 4'd6, 4'd1, 4'd5, 4'd3, 4'd7};
   localparam logic [3:0] BRIGHT_MAP [8] =
      '{4'd8, 4'd12, 4'd10, 4'd14, 4'd9, 4'd13, 4'd11, 4'd15};

   typedef enum logic [1:0] {
      CMD_DRAW   = 2'd0,
      CMD_ERASE  = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_SCROLL = 2'd3
   } rsp_cmd_type;

   typedef enum logic [1:0] {PH_NORMAL, PH_ESCAPE, PH_BRACKET, PH_PARAM} phase_type;

   typedef enum logic [1:0] {RD_LAST, RD_ZERO, RD_ONE, RD_NEXT} rd_sel_type;
   typedef enum logic [2:0] {CUR_HOLD, CUR_CLAMP, CUR_TEXT, CUR_HOME, CUR_ROW, CUR_COL}
      cur_op_type;
   typedef enum logic [1:0] {CNT_HOLD, CNT_CLEAR, CNT_FIRST, CNT_INC} cnt_op_type;
   typedef enum logic [1:0] {WR_NONE, WR_DIGIT, WR_ZERO_FIRST, WR_ZERO_NEXT} wr_op_type;
   typedef enum logic [1:0] {SGR_NONE, SGR_DEFAULT, SGR_APPLY} sgr_op_type;
   typedef enum logic [1:0] {OUT_NONE, OUT_FIRST, OUT_SCROLL, OUT_CLEAR} out_op_type;

   typedef struct packed {
      logic       byte_load;
      logic       rd_en;
      rd_sel_type rd_sel;
      cur_op_type cur_op;
      cnt_op_type cnt_op;
      wr_op_type  wr_op;
      sgr_op_type sgr_op;
      out_op_type out_op;
   } dp_cmd_type;

   typedef struct packed {
      logic is_esc;
      logic is_lbr;
      logic is_digit;
      logic is_semi;
      logic is_sgr;
      logic is_ed;
      logic is_cup;
      logic count_zero;
      logic count_below_max;
      logic sgr_last;
      logic erase_ok;
      logic first_pend;
      logic scroll_pend;
      logic out_free;
   } dp_status_type;

   typedef struct packed {
      logic       bold;
      logic [3:0] fore;
      logic [3:0] back;
   } attr_type;

   function automatic attr_type sgr_apply(input logic [31:0] code, input attr_type cur);
      attr_type    nxt;
      logic [31:0] off;
      nxt = cur;
      off = 32'd0;
      if (code == SGR_RESET) begin
         nxt.bold = 1'b0;
         nxt.fore = FORE_RESET;
         nxt.back = BACK_RESET;
      end else if (code == SGR_BOLD) begin
         nxt.bold = 1'b1;
      end else if (code == SGR_NORMAL) begin
         nxt.bold = 1'b0;
      end else if (code inside {[SGR_FG_FIRST:SGR_FG_LAST]}) begin
         off = code - SGR_FG_FIRST;
         nxt.fore = cur.bold ? BRIGHT_MAP[off[2:0]] : BASE_MAP[off[2:0]];
      end else if (code == SGR_FG_DEFAULT) begin
         nxt.fore = FORE_RESET;
      end else if (code inside {[SGR_BG_FIRST:SGR_BG_LAST]}) begin
         off = code - SGR_BG_FIRST;
         nxt.back = BASE_MAP[off[2:0]];
      end else if (code == SGR_BG_DEFAULT) begin
         nxt.back = BACK_RESET;
      end else if (code inside {[SGR_FG_BRIGHT_FIRST:SGR_FG_BRIGHT_LAST]}) begin
         off = code - SGR_FG_BRIGHT_FIRST;
         nxt.fore = BRIGHT_MAP[off[2:0]];
      end else if (code inside {[SGR_BG_BRIGHT_FIRST:SGR_BG_BRIGHT_LAST]}) begin
         off = code - SGR_BG_BRIGHT_FIRST;
         nxt.back = BRIGHT_MAP[off[2:0]];
      end
      return nxt;
   endfunction

endpackage

### rtl/attc_ctrl.sv
// Sequencer of the terminal controller: escape parser phase and per-byte step control.
module attc_ctrl
   import attc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [11:0] {
      ST_IDLE   = 12'b0000_0000_0001,
      ST_DECODE = 12'b0000_0000_0010,
      ST_DIGIT  = 12'b0000_0000_0100,
      ST_SEMI   = 12'b0000_0000_1000,
      ST_SGR    = 12'b0000_0001_0000,
      ST_ED_CHK = 12'b0000_0010_0000,
      ST_ED_OUT = 12'b0000_0100_0000,
      ST_H_ROW  = 12'b0000_1000_0000,
      ST_H_COL  = 12'b0001_0000_0000,
      ST_TEXT   = 12'b0010_0000_0000,
      ST_EMIT1  = 12'b0100_0000_0000,
      ST_EMIT2  = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.byte_load = 1'b1;
               state_in      = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.cur_op = CUR_CLAMP;
            state_in   = ST_IDLE;
            case (phase_ff)
               PH_NORMAL: begin
                  if (status.is_esc) phase_in = PH_ESCAPE;
                  else state_in = ST_TEXT;
               end
               PH_ESCAPE: begin
                  if (status.is_lbr) begin
                     phase_in   = PH_BRACKET;
                     cmd.cnt_op = CNT_CLEAR;
                  end else begin
                     phase_in = PH_NORMAL;
                     state_in = ST_TEXT;
                  end
               end
               default: begin
                  if (status.is_digit) begin
                     phase_in   = PH_PARAM;
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_LAST;
                     cmd.cnt_op = CNT_FIRST;
                     state_in   = ST_DIGIT;
                  end else if (status.is_semi) begin
                     if (status.count_below_max) begin
                        if (status.count_zero) begin
                           // open the first parameter, the second follows next cycle
                           cmd.wr_op  = WR_ZERO_FIRST;
                           cmd.cnt_op = CNT_FIRST;
                           state_in   = ST_SEMI;
                        end else begin
                           cmd.wr_op  = WR_ZERO_NEXT;
                           cmd.cnt_op = CNT_INC;
                        end
                     end
                  end else if (status.is_sgr) begin
                     phase_in = PH_NORMAL;
                     if (status.count_zero) begin
                        cmd.sgr_op = SGR_DEFAULT;
                     end else begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_ZERO;
                        state_in   = ST_SGR;
                     end
                  end else if (status.is_ed) begin
                     phase_in   = PH_NORMAL;
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_ZERO;
                     state_in   = ST_ED_CHK;
                  end else if (status.is_cup) begin
                     phase_in   = PH_NORMAL;
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_ZERO;
                     state_in   = ST_H_ROW;
                  end else begin
                     // unknown final: drop sequence, byte goes out as text
                     phase_in   = PH_NORMAL;
                     cmd.cnt_op = CNT_CLEAR;
                     state_in   = ST_TEXT;
                  end
               end
            endcase
         end
         ST_DIGIT: begin
            cmd.wr_op = WR_DIGIT;
            state_in  = ST_IDLE;
         end
         ST_SEMI: begin
            cmd.wr_op  = WR_ZERO_NEXT;
            cmd.cnt_op = CNT_INC;
            state_in   = ST_IDLE;
         end
         ST_SGR: begin
            cmd.sgr_op = SGR_APPLY;
            if (status.sgr_last) begin
               cmd.cnt_op = CNT_CLEAR;
               state_in   = ST_IDLE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_NEXT;
            end
         end
         ST_ED_CHK: begin
            cmd.cnt_op = CNT_CLEAR;
            state_in   = status.erase_ok ? ST_ED_OUT : ST_IDLE;
         end
         ST_ED_OUT: begin
            if (status.out_free) begin
               cmd.out_op = OUT_CLEAR;
               cmd.cur_op = CUR_HOME;
               state_in   = ST_IDLE;
            end
         end
         ST_H_ROW: begin
            cmd.cur_op = CUR_ROW;
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_ONE;
            state_in   = ST_H_COL;
         end
         ST_H_COL: begin
            cmd.cur_op = CUR_COL;
            cmd.cnt_op = CNT_CLEAR;
            state_in   = ST_IDLE;
         end
         ST_TEXT: begin
            cmd.cur_op = CUR_TEXT;
            state_in   = ST_EMIT1;
         end
         ST_EMIT1: begin
            if (!status.first_pend) begin
               state_in = ST_EMIT2;
            end else if (status.out_free) begin
               cmd.out_op = OUT_FIRST;
               state_in   = ST_EMIT2;
            end
         end
         ST_EMIT2: begin
            if (!status.scroll_pend) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.out_op = OUT_SCROLL;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_NORMAL;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

endmodule

### rtl/attc_dp.sv
// Datapath of the terminal controller: screen size, parameter memory, attributes,
// cursor and the result register.
module attc_dp
   import attc_pkg::*;
#(
   parameter int MAX_PARAMS = 8,
   parameter int PARAM_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_write_enable,
   input  logic          csr_index,
   input  logic [7:0]    csr_write_data,
   input  logic [7:0]    req_char_byte,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [1:0]    rsp_command,
   output logic [7:0]    rsp_cell_column,
   output logic [6:0]    rsp_cell_row,
   output logic [7:0]    rsp_glyph_code,
   output logic [3:0]    rsp_fore_index,
   output logic [3:0]    rsp_back_index,
   output logic          rsp_last_of_run
);

   localparam int CNT_W = $clog2(MAX_PARAMS + 1);
   localparam int IDX_W = $clog2(MAX_PARAMS);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PARAMS);

   logic [7:0]            cols_ff, cols_in;
   logic [6:0]            rows_ff, rows_in;
   logic [7:0]            byte_ff, byte_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  fresh_ff, fresh_in;
   logic [PARAM_BITS-1:0] rd_data_ff;
   logic [PARAM_BITS-1:0] param_store [MAX_PARAMS];
   attr_type              attr_ff, attr_in;
   logic [7:0]            col_ff, col_in;
   logic [6:0]            row_ff, row_in;
   logic                  first_pend_ff, first_pend_in;
   logic                  scroll_pend_ff, scroll_pend_in;
   rsp_cmd_type           pend_cmd_ff, pend_cmd_in;
   logic [7:0]            pend_col_ff, pend_col_in;
   logic [6:0]            pend_row_ff, pend_row_in;
   logic [7:0]            pend_glyph_ff, pend_glyph_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_cmd_type           rsp_command_ff, rsp_command_in;
   logic [7:0]            rsp_col_ff, rsp_col_in;
   logic [6:0]            rsp_row_ff, rsp_row_in;
   logic [7:0]            rsp_glyph_ff, rsp_glyph_in;
   logic [3:0]            rsp_fore_ff, rsp_fore_in;
   logic [3:0]            rsp_back_ff, rsp_back_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [7:0]            cols_eff;
   logic [6:0]            rows_eff;
   logic                  count_zero;
   logic [CNT_W-1:0]      count_m1;
   logic [IDX_W-1:0]      idx_next;
   logic [IDX_W-1:0]      rd_addr;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [PARAM_BITS-1:0] wr_data;
   logic [PARAM_BITS-1:0] acc_old;
   logic [PARAM_BITS+3:0] acc_wide;
   logic [PARAM_BITS-1:0] acc_new;
   logic [31:0]           prm32;
   logic [31:0]           h_pos;
   logic [7:0]            h_col;
   logic [6:0]            h_row;
   logic [8:0]            t_col9;
   logic [7:0]            t_row8;
   logic                  t_first;
   rsp_cmd_type           t_cmd;
   logic [7:0]            t_cell_col;
   logic [7:0]            t_glyph;
   logic                  t_scroll;
   logic                  out_free;

   assign cols_eff   = (cols_ff == 8'd0) ? 8'd1 : cols_ff;
   assign rows_eff   = (rows_ff == 7'd0) ? 7'd1 : rows_ff;
   assign count_zero = (count_ff == '0);
   assign count_m1   = count_ff - CNT_W'(1);
   assign idx_next   = idx_ff + IDX_W'(1);
   assign prm32      = 32'(rd_data_ff);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // parameter memory, one read port with registered data
   always_comb begin
      case (cmd.rd_sel)
         RD_LAST: rd_addr = count_zero ? '0 : count_m1[IDX_W-1:0];
         RD_ZERO: rd_addr = '0;
         RD_ONE:  rd_addr = IDX_W'(1);
         RD_NEXT: rd_addr = idx_next;
         default: rd_addr = '0;
      endcase
   end

   // decimal accumulate with saturation: v*10 + d
   assign acc_old  = fresh_ff ? '0 : rd_data_ff;
   assign acc_wide = ((PARAM_BITS+4)'(acc_old) << 3) + ((PARAM_BITS+4)'(acc_old) << 1)
                   + (PARAM_BITS+4)'(byte_ff[3:0]);
   assign acc_new  = (|acc_wide[PARAM_BITS+3:PARAM_BITS]) ? '1 : acc_wide[PARAM_BITS-1:0];

   always_comb begin
      wr_en   = (cmd.wr_op != WR_NONE);
      wr_addr = '0;
      wr_data = '0;
      case (cmd.wr_op)
         WR_DIGIT: begin
            wr_addr = count_m1[IDX_W-1:0];
            wr_data = acc_new;
         end
         WR_ZERO_FIRST: wr_addr = '0;
         WR_ZERO_NEXT:  wr_addr = count_ff[IDX_W-1:0];
         default:       wr_addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) param_store[wr_addr] <= wr_data;
      if (cmd.rd_en) rd_data_ff <= param_store[rd_addr];
   end

   // cursor placement, 1-based, clamped
   always_comb begin
      h_pos = 32'd0;
      if (cmd.cur_op == CUR_ROW) begin
         if (!count_zero && prm32 != 32'd0) h_pos = prm32 - 32'd1;
      end else begin
         if (count_ff > CNT_W'(1) && prm32 != 32'd0) h_pos = prm32 - 32'd1;
      end
      h_row = (h_pos < 32'(rows_eff)) ? h_pos[6:0] : rows_eff - 7'd1;
      h_col = (h_pos < 32'(cols_eff)) ? h_pos[7:0] : cols_eff - 8'd1;
   end

   // text step: move, wrap, scroll
   always_comb begin
      t_col9     = {1'b0, col_ff};
      t_row8     = {1'b0, row_ff};
      t_first    = 1'b0;
      t_cmd      = CMD_DRAW;
      t_cell_col = col_ff;
      t_glyph    = 8'd0;
      case (byte_ff)
         LF_CODE: begin
            t_col9 = 9'd0;
            t_row8 = t_row8 + 8'd1;
         end
         CR_CODE: t_col9 = 9'd0;
         TAB_CODE: t_col9 = (t_col9 + TAB_STEP) & TAB_MASK;
         BS_CODE: begin
            if (col_ff != 8'd0) begin
               t_col9     = t_col9 - 9'd1;
               t_first    = 1'b1;
               t_cmd      = CMD_ERASE;
               t_cell_col = col_ff - 8'd1;
            end
         end
         default: begin
            t_first = 1'b1;
            t_glyph = byte_ff;
            t_col9  = t_col9 + 9'd1;
         end
      endcase
      if (t_col9 >= {1'b0, cols_eff}) begin
         t_col9 = 9'd0;
         t_row8 = t_row8 + 8'd1;
      end
      t_scroll = (t_row8 >= {1'b0, rows_eff});
      if (t_scroll) t_row8 = {1'b0, rows_eff - 7'd1};
   end

   always_comb begin
      cols_in        = cols_ff;
      rows_in        = rows_ff;
      byte_in        = cmd.byte_load ? req_char_byte : byte_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      fresh_in       = fresh_ff;
      attr_in        = attr_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      first_pend_in  = first_pend_ff;
      scroll_pend_in = scroll_pend_ff;
      pend_cmd_in    = pend_cmd_ff;
      pend_col_in    = pend_col_ff;
      pend_row_in    = pend_row_ff;
      pend_glyph_in  = pend_glyph_ff;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_TEXT_COLUMNS: cols_in = csr_write_data;
            CSR_TEXT_ROWS:    rows_in = csr_write_data[6:0];
            default: ;
         endcase
      end

      case (cmd.cnt_op)
         CNT_CLEAR: count_in = '0;
         CNT_FIRST: if (count_zero) count_in = CNT_W'(1);
         CNT_INC:   count_in = count_ff + CNT_W'(1);
         default: ;
      endcase

      if (cmd.rd_en) begin
         case (cmd.rd_sel)
            RD_LAST: fresh_in = count_zero;
            RD_ZERO: idx_in = '0;
            RD_NEXT: idx_in = idx_next;
            default: ;
         endcase
      end

      case (cmd.sgr_op)
         SGR_DEFAULT: attr_in = sgr_apply(SGR_RESET, attr_ff);
         SGR_APPLY:   attr_in = sgr_apply(prm32, attr_ff);
         default: ;
      endcase

      case (cmd.cur_op)
         CUR_CLAMP: begin
            if (col_ff >= cols_eff) col_in = cols_eff - 8'd1;
            if (row_ff >= rows_eff) row_in = rows_eff - 7'd1;
         end
         CUR_TEXT: begin
            col_in         = t_col9[7:0];
            row_in         = t_row8[6:0];
            first_pend_in  = t_first;
            scroll_pend_in = t_scroll;
            pend_cmd_in    = t_cmd;
            pend_col_in    = t_cell_col;
            pend_row_in    = row_ff;
            pend_glyph_in  = t_glyph;
         end
         CUR_HOME: begin
            col_in = 8'd0;
            row_in = 7'd0;
         end
         CUR_ROW: row_in = h_row;
         CUR_COL: col_in = h_col;
         default: ;
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_command_in = rsp_command_ff;
      rsp_col_in     = rsp_col_ff;
      rsp_row_in     = rsp_row_ff;
      rsp_glyph_in   = rsp_glyph_ff;
      rsp_fore_in    = rsp_fore_ff;
      rsp_back_in    = rsp_back_ff;
      rsp_last_in    = rsp_last_ff;
      if (cmd.out_op != OUT_NONE) begin
         rsp_valid_in = 1'b1;
         rsp_fore_in  = attr_ff.fore;
         rsp_back_in  = attr_ff.back;
         rsp_col_in   = 8'd0;
         rsp_row_in   = 7'd0;
         rsp_glyph_in = 8'd0;
         rsp_last_in  = 1'b1;
      end
      case (cmd.out_op)
         OUT_FIRST: begin
            rsp_command_in = pend_cmd_ff;
            rsp_col_in     = pend_col_ff;
            rsp_row_in     = pend_row_ff;
            rsp_glyph_in   = pend_glyph_ff;
            rsp_last_in    = !scroll_pend_ff;
         end
         OUT_SCROLL: rsp_command_in = CMD_SCROLL;
         OUT_CLEAR:  rsp_command_in = CMD_CLEAR;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff        <= COLS_RESET;
         rows_ff        <= ROWS_RESET;
         count_ff       <= '0;
         idx_ff         <= '0;
         fresh_ff       <= 1'b0;
         attr_ff        <= '{bold: 1'b0, fore: FORE_RESET, back: BACK_RESET};
         col_ff         <= 8'd0;
         row_ff         <= 7'd0;
         first_pend_ff  <= 1'b0;
         scroll_pend_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         cols_ff        <= cols_in;
         rows_ff        <= rows_in;
         count_ff       <= count_in;
         idx_ff         <= idx_in;
         fresh_ff       <= fresh_in;
         attr_ff        <= attr_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         first_pend_ff  <= first_pend_in;
         scroll_pend_ff <= scroll_pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff        <= byte_in;
      pend_cmd_ff    <= pend_cmd_in;
      pend_col_ff    <= pend_col_in;
      pend_row_ff    <= pend_row_in;
      pend_glyph_ff  <= pend_glyph_in;
      rsp_command_ff <= rsp_command_in;
      rsp_col_ff     <= rsp_col_in;
      rsp_row_ff     <= rsp_row_in;
      rsp_glyph_ff   <= rsp_glyph_in;
      rsp_fore_ff    <= rsp_fore_in;
      rsp_back_ff    <= rsp_back_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign status.is_esc          = (byte_ff == ESC_CODE);
   assign status.is_lbr          = (byte_ff == LBR_CODE);
   assign status.is_digit        = byte_ff inside {[DIGIT0_CODE:DIGIT9_CODE]};
   assign status.is_semi         = (byte_ff == SEMI_CODE);
   assign status.is_sgr          = (byte_ff == SGR_FINAL);
   assign status.is_ed           = (byte_ff == ED_FINAL);
   assign status.is_cup          = (byte_ff == CUP_FINAL);
   assign status.count_zero      = count_zero;
   assign status.count_below_max = (count_ff < CNT_MAX);
   assign status.sgr_last        = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   assign status.erase_ok        = count_zero ? 1'b1 : (prm32 == ED_TO_END || prm32 == ED_ALL);
   assign status.first_pend      = first_pend_ff;
   assign status.scroll_pend     = scroll_pend_ff;
   assign status.out_free        = out_free;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_command     = rsp_command_ff;
   assign rsp_cell_column = rsp_col_ff;
   assign rsp_cell_row    = rsp_row_ff;
   assign rsp_glyph_code  = rsp_glyph_ff;
   assign rsp_fore_index  = rsp_fore_ff;
   assign rsp_back_index  = rsp_back_ff;
   assign rsp_last_of_run = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("parameter count beyond limit");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_op != OUT_NONE) |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten while held");

   a_text_cursor: assert property (@(posedge clock) disable iff (reset)
      (cmd.cur_op == CUR_TEXT) |=> (col_ff < $past(cols_eff)) && (row_ff < $past(rows_eff)))
      else $error("cursor left the screen after a text step");

   a_scroll_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_command_ff == CMD_SCROLL) |-> rsp_last_ff)
      else $error("scroll is not the final command of its byte");
`endif

endmodule

### rtl/ansi_text_terminal_controller_core.sv
// Top level of the ANSI text terminal controller: sequencer plus datapath.
//
// Takes one byte per transaction and returns rendering commands (draw, erase,
// clear, scroll) with VGA palette indices. A byte is taken only while the
// sequencer is idle, so a new byte waits until the previous one is finished.
// Digits are decoded and then accumulated into the parameter memory. SGR walks
// its stored parameters one entry a cycle, since the parameter memory has one
// read port; H sets the row and then the column, and J checks its argument
// and then gives the clear command. Text bytes and J wait while the result
// side stalls. A byte gives at most two commands, the final one flagged with
// last_of_run. A single output register holds the command waiting to be taken.
module ansi_text_terminal_controller_core
   import attc_pkg::*;
#(
   parameter int MAX_PARAMS = 8,
   parameter int PARAM_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic [7:0] csr_write_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_command,
   output logic [7:0] rsp_cell_column,
   output logic [6:0] rsp_cell_row,
   output logic [7:0] rsp_glyph_code,
   output logic [3:0] rsp_fore_index,
   output logic [3:0] rsp_back_index,
   output logic       rsp_last_of_run
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   attc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   attc_dp #(
      .MAX_PARAMS (MAX_PARAMS),
      .PARAM_BITS (PARAM_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_char_byte    (req_char_byte),
      .cmd              (dp_cmd),
      .status           (dp_status),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_command      (rsp_command),
      .rsp_cell_column  (rsp_cell_column),
      .rsp_cell_row     (rsp_cell_row),
      .rsp_glyph_code   (rsp_glyph_code),
      .rsp_fore_index   (rsp_fore_index),
      .rsp_back_index   (rsp_back_index),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule

### sim/tb_ansi_text_terminal_controller_core.sv
// Self-checking testbench for the ANSI text terminal controller core.
`timescale 1ns / 100ps

module tb_ansi_text_terminal_controller_core;
   import attc_pkg::*;

   localparam int MAX_ARGS = 8;
   localparam int ARG_BITS = 16;
   localparam int unsigned ARG_MAX = (1 << ARG_BITS) - 1;
   localparam int unsigned NO_ARG = 32'hFFFF_FFFF;  // parameter left empty
   localparam int RANDOM_ITEMS = 1700;
   localparam int SETTLE_CYCLES = 24;
   localparam int HOLD_CYCLES = 500;
   localparam int QUIET_LIMIT = 4000;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_style_type;

   typedef struct {
      rsp_cmd_type cmd;
      logic [7:0]  column;
      logic [6:0]  row;
      logic [7:0]  glyph;
      logic [3:0]  fore;
      logic [3:0]  back;
      logic        last;
   } render_cmd_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       csr_write_enable = 1'b0;
   logic       csr_index = CSR_TEXT_COLUMNS;
   logic [7:0] csr_write_data = 8'd0;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_char_byte = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_command;
   logic [7:0] rsp_cell_column;
   logic [6:0] rsp_cell_row;
   logic [7:0] rsp_glyph_code;
   logic [3:0] rsp_fore_index;
   logic [3:0] rsp_back_index;
   logic       rsp_last_of_run;

   ansi_text_terminal_controller_core #(
      .MAX_PARAMS(MAX_ARGS),
      .PARAM_BITS(ARG_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_char_byte(req_char_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_command(rsp_command),
      .rsp_cell_column(rsp_cell_column),
      .rsp_cell_row(rsp_cell_row),
      .rsp_glyph_code(rsp_glyph_code),
      .rsp_fore_index(rsp_fore_index),
      .rsp_back_index(rsp_back_index),
      .rsp_last_of_run(rsp_last_of_run)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // terminal state as the block should hold it
   logic [7:0]  screen_cols = COLS_RESET;
   logic [6:0]  screen_rows = ROWS_RESET;
   phase_type   term_phase = PH_NORMAL;
   int unsigned arg_vals[MAX_ARGS];
   int unsigned arg_count = 0;
   logic        bold_on = 1'b0;
   logic [3:0]  fore_now = FORE_RESET;
   logic [3:0]  back_now = BACK_RESET;
   int unsigned cursor_x = 0;
   int unsigned cursor_y = 0;
   logic [3:0]  ansi_to_vga [8] = '{4'd0, 4'd4, 4'd2, 4'd6, 4'd1, 4'd5, 4'd3, 4'd7};

   render_cmd_type  pending_cmds[$];
   int              error_count = 0;
   int unsigned     bytes_sent = 0;
   logic            sender_pauses = 1'b1;
   int              burst_left = 0;
   logic            hold_request = 1'b0;
   int              hold_left = 0;
   int              mode_left = 0;
   stall_style_type stall_mode = STALL_NONE;
   int              quiet_cycles = 0;

   function automatic render_cmd_type make_cmd(
      input rsp_cmd_type cmd, input int unsigned column,
      input int unsigned row, input logic [7:0] glyph);
      render_cmd_type c;
      c.cmd = cmd;
      c.column = 8'(column);
      c.row = 7'(row);
      c.glyph = glyph;
      c.fore = fore_now;
      c.back = back_now;
      c.last = 1'b0;
      return c;
   endfunction

   function automatic void apply_attributes(input int unsigned count);
      int unsigned code;
      int unsigned i;
      if (count == 0) begin
         count = 1;
         arg_vals[0] = 0;
      end
      for (i = 0; i < count; i++) begin
         code = arg_vals[i];
         if (code == SGR_RESET) begin
            fore_now = FORE_RESET;
            back_now = BACK_RESET;
            bold_on = 1'b0;
         end else if (code == SGR_BOLD) begin
            bold_on = 1'b1;
         end else if (code == SGR_NORMAL) begin
            bold_on = 1'b0;
         end else if (code >= SGR_FG_FIRST && code <= SGR_FG_LAST) begin
            fore_now = ansi_to_vga[code - SGR_FG_FIRST] | {bold_on, 3'b000};
         end else if (code == SGR_FG_DEFAULT) begin
            fore_now = FORE_RESET;
         end else if (code >= SGR_BG_FIRST && code <= SGR_BG_LAST) begin
            back_now = ansi_to_vga[code - SGR_BG_FIRST];
         end else if (code == SGR_BG_DEFAULT) begin
            back_now = BACK_RESET;
         end else if (code >= SGR_FG_BRIGHT_FIRST && code <= SGR_FG_BRIGHT_LAST) begin
            fore_now = ansi_to_vga[code - SGR_FG_BRIGHT_FIRST] | 4'b1000;
         end else if (code >= SGR_BG_BRIGHT_FIRST && code <= SGR_BG_BRIGHT_LAST) begin
            back_now = ansi_to_vga[code - SGR_BG_BRIGHT_FIRST] | 4'b1000;
         end
      end
   endfunction

   // advance the terminal by one byte and queue the commands it must produce
   function automatic void predict_commands(input logic [7:0] ch);
      render_cmd_type fresh[$];
      int unsigned    cols, rows, x, y, d, v, p, q;
      int unsigned    count;
      logic           as_text;
      cols = (screen_cols == 0) ? 1 : screen_cols;
      rows = (screen_rows == 0) ? 1 : screen_rows;
      as_text = 1'b1;
      if (cursor_x >= cols) cursor_x = cols - 1;
      if (cursor_y >= rows) cursor_y = rows - 1;
      case (term_phase)
         PH_NORMAL: begin
            if (ch == ESC_CODE) begin
               term_phase = PH_ESCAPE;
               as_text = 1'b0;
            end
         end
         PH_ESCAPE: begin
            term_phase = PH_NORMAL;
            if (ch == LBR_CODE) begin
               term_phase = PH_BRACKET;
               arg_count = 0;
               as_text = 1'b0;
            end
         end
         default: begin
            if (ch >= DIGIT0_CODE && ch <= DIGIT9_CODE) begin
               d = ch - DIGIT0_CODE;
               if (arg_count == 0) begin
                  arg_count = 1;
                  arg_vals[0] = 0;
               end
               v = arg_vals[arg_count - 1];
               v = (v > (ARG_MAX - d) / 10) ? ARG_MAX : v * 10 + d;
               arg_vals[arg_count - 1] = v;
               term_phase = PH_PARAM;
               as_text = 1'b0;
            end else if (ch == SEMI_CODE) begin
               // past the last slot, separators are dropped
               if (arg_count < MAX_ARGS) begin
                  if (arg_count == 0) begin
                     arg_count = 1;
                     arg_vals[0] = 0;
                  end
                  arg_vals[arg_count] = 0;
                  arg_count++;
               end
               as_text = 1'b0;
            end else begin
               p = (arg_count > 0) ? arg_vals[0] : 0;
               q = (arg_count > 1) ? arg_vals[1] : 0;
               count = arg_count;
               term_phase = PH_NORMAL;
               arg_count = 0;
               if (ch == SGR_FINAL) begin
                  apply_attributes(count);
                  as_text = 1'b0;
               end else if (ch == ED_FINAL) begin
                  if (p == ED_TO_END || p == ED_ALL) begin
                     fresh.push_back(make_cmd(CMD_CLEAR, 0, 0, 8'd0));
                     cursor_x = 0;
                     cursor_y = 0;
                  end
                  as_text = 1'b0;
               end else if (ch == CUP_FINAL) begin
                  p = (p > 0) ? p - 1 : 0;
                  q = (q > 0) ? q - 1 : 0;
                  cursor_y = (p < rows) ? p : rows - 1;
                  cursor_x = (q < cols) ? q : cols - 1;
                  as_text = 1'b0;
               end
            end
         end
      endcase
      if (as_text) begin
         x = cursor_x;
         y = cursor_y;
         if (ch == LF_CODE) begin
            x = 0;
            y++;
         end else if (ch == CR_CODE) begin
            x = 0;
         end else if (ch == TAB_CODE) begin
            x = (x + TAB_STEP) & TAB_MASK;
         end else if (ch == BS_CODE) begin
            if (x > 0) begin
               x--;
               fresh.push_back(make_cmd(CMD_ERASE, x, y, 8'd0));
            end
         end else begin
            fresh.push_back(make_cmd(CMD_DRAW, x, y, ch));
            x++;
         end
         if (x >= cols) begin
            x = 0;
            y++;
         end
         if (y >= rows) begin
            fresh.push_back(make_cmd(CMD_SCROLL, 0, 0, 8'd0));
            y = rows - 1;
         end
         cursor_x = x;
         cursor_y = y;
      end
      if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
      foreach (fresh[i]) pending_cmds.push_back(fresh[i]);
   endfunction

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // command checker
   always @(posedge clock) begin
      render_cmd_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_cmds.size() == 0) begin
            $error("command %0d at column %0d row %0d with nothing expected",
                   rsp_command, rsp_cell_column, rsp_cell_row);
            error_count++;
         end else begin
            want = pending_cmds.pop_front();
            check_field("command", want.cmd, rsp_command);
            check_field("cell_column", want.column, rsp_cell_column);
            check_field("cell_row", want.row, rsp_cell_row);
            check_field("glyph_code", want.glyph, rsp_glyph_code);
            check_field("fore_index", want.fore, rsp_fore_index);
            check_field("back_index", want.back, rsp_back_index);
            check_field("last_of_run", want.last, rsp_last_of_run);
         end
      end
   end

   // receiver: changing stall styles, plus a long hold on request
   always @(posedge clock) begin
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (mode_left == 0) begin
         stall_mode = stall_style_type'($urandom_range(0, 3));
         mode_left = $urandom_range(16, 160);
      end else begin
         mode_left--;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            STALL_NONE: rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic send_byte(input logic [7:0] ch);
      int gap;
      req_valid <= 1'b1;
      req_char_byte <= ch;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_commands(ch);
      bytes_sent++;
      if (sender_pauses) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(0, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   endtask

   task automatic send_text(input string s);
      foreach (s[i]) send_byte(s[i]);
   endtask

   task automatic send_number(input int unsigned value);
      logic [7:0] digits[$];
      do begin
         digits.push_front(DIGIT0_CODE + 8'(value % 10));
         value /= 10;
      end while (value != 0);
      foreach (digits[i]) send_byte(digits[i]);
   endtask

   task automatic send_csi(input int unsigned args[$], input logic [7:0] final_byte);
      send_byte(ESC_CODE);
      send_byte(LBR_CODE);
      foreach (args[i]) begin
         if (i > 0) send_byte(SEMI_CODE);
         if (args[i] != NO_ARG) send_number(args[i]);
      end
      send_byte(final_byte);
   endtask

   // stop offering, let every expected command drain, then let the block settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_screen(input logic [7:0] cols, input logic [7:0] rows);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_index <= CSR_TEXT_COLUMNS;
      csr_write_data <= cols;
      @(posedge clock);
      screen_cols = cols;
      csr_index <= CSR_TEXT_ROWS;
      csr_write_data <= rows;
      @(posedge clock);
      screen_rows = rows[6:0];
      csr_write_enable <= 1'b0;
   endtask

   task automatic test_plain_text();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h80);
      send_byte(8'h7F);
      send_text("A");
      // ESC without bracket: the following byte is plain text, even another ESC
      send_byte(ESC_CODE);
      send_text("Q");
      send_byte(ESC_CODE);
      send_byte(ESC_CODE);
   endtask

   task automatic test_cursor_moves();
      set_screen(8'd6, 8'd3);
      send_text("ab");
      send_byte(TAB_CODE);
      send_text("cd");
      send_byte(CR_CODE);
      send_byte(BS_CODE);
      send_text("x");
      send_byte(BS_CODE);
      send_byte(LF_CODE);
      send_byte(LF_CODE);
      send_byte(LF_CODE);
      send_byte(TAB_CODE);
      send_byte(TAB_CODE);
   endtask

   task automatic test_attributes();
      set_screen(COLS_RESET, {1'b0, ROWS_RESET});
      send_csi('{NO_ARG}, SGR_FINAL);
      send_csi('{SGR_FG_FIRST + 1}, SGR_FINAL);
      send_text("a");
      send_csi('{SGR_BOLD, SGR_FG_FIRST + 4, SGR_BG_FIRST + 3}, SGR_FINAL);
      send_text("b");
      send_csi('{SGR_NORMAL, SGR_FG_BRIGHT_LAST, SGR_BG_BRIGHT_FIRST}, SGR_FINAL);
      send_text("c");
      // last code saturates and is ignored
      send_csi('{SGR_FG_DEFAULT, SGR_BG_DEFAULT, SGR_BG_LAST, 12345678}, SGR_FINAL);
      send_text("d");
      // extra parameters fold their digits into the last slot
      send_csi('{SGR_BOLD, SGR_NORMAL, SGR_BOLD, SGR_NORMAL, SGR_BOLD, SGR_NORMAL, SGR_BOLD,
                 SGR_FG_FIRST, SGR_FG_LAST, SGR_BG_LAST}, SGR_FINAL);
      send_text("e");
      send_csi('{SGR_BG_BRIGHT_LAST, SGR_FG_BRIGHT_FIRST}, SGR_FINAL);
      send_text("f");
   endtask

   task automatic test_erase_and_position();
      send_text("xy");
      send_csi('{ED_ALL}, ED_FINAL);
      send_csi('{ED_ALL + 1}, ED_FINAL);
      send_csi('{NO_ARG}, ED_FINAL);
      send_csi('{5, 10}, CUP_FINAL);
      send_text("p");
      send_csi('{NO_ARG, 7}, CUP_FINAL);
      send_text("q");
      send_csi('{900, 900}, CUP_FINAL);
      send_text("r");
      send_csi('{0, 0, 4}, CUP_FINAL);
      send_csi('{4}, "q");
      send_csi('{ED_TO_END}, ED_FINAL);
   endtask

   task automatic test_screen_sizes();
      set_screen(8'd0, 8'd0);
      send_text("ab\n");
      set_screen(8'd1, 8'd1);
      send_text("c");
      send_byte(BS_CODE);
      send_byte(TAB_CODE);
      set_screen(8'd255, 8'hFF);
      send_csi('{120, 250}, CUP_FINAL);
      send_text("d");
      // shrinking leaves the cursor off screen until the next byte clamps it
      set_screen(8'd12, 8'd5);
      send_text("e");
      send_byte(BS_CODE);
      set_screen(8'd255, 8'd127);
      send_csi('{127, 255}, CUP_FINAL);
      send_text("gh");
   endtask

   task automatic test_backpressure();
      int i;
      sender_pauses = 1'b0;
      hold_request = 1'b1;
      for (i = 0; i < 48; i++) begin
         if (i % 12 == 11) send_byte(LF_CODE);
         else send_byte(8'($urandom_range(8'h20, 8'h7E)));
      end
      sender_pauses = 1'b1;
   endtask

   function automatic int unsigned pick_sgr_arg();
      case ($urandom_range(0, 11))
         0: return SGR_RESET;
         1: return SGR_BOLD;
         2: return SGR_NORMAL;
         3, 4: return SGR_FG_FIRST + $urandom_range(0, 7);
         5: return SGR_BG_FIRST + $urandom_range(0, 7);
         6: return SGR_FG_BRIGHT_FIRST + $urandom_range(0, 7);
         7: return SGR_BG_BRIGHT_FIRST + $urandom_range(0, 7);
         8: return $urandom_range(0, 1) ? SGR_FG_DEFAULT : SGR_BG_DEFAULT;
         9: return NO_ARG;
         10: return $urandom_range(0, 120);
         default: return $urandom_range(0, 99_999_999);
      endcase
   endfunction

   task automatic random_screen();
      logic [7:0] c, r;
      case ($urandom_range(0, 5))
         0: begin
            c = 8'($urandom_range(0, 255));
            r = 8'($urandom_range(0, 255));
         end
         1: begin
            c = COLS_RESET;
            r = {1'b0, ROWS_RESET};
         end
         default: begin
            c = 8'($urandom_range(1, 24));
            r = 8'($urandom_range(1, 8));
         end
      endcase
      set_screen(c, r);
   endtask

   task automatic test_random_stream();
      int unsigned goal;
      int unsigned args[$];
      int          kind, n, i;
      goal = bytes_sent + RANDOM_ITEMS;
      while (bytes_sent < goal) begin
         if ($urandom_range(0, 79) == 0) random_screen();
         kind = $urandom_range(0, 99);
         args.delete();
         if (kind < 35) begin
            n = $urandom_range(1, 8);
            for (i = 0; i < n; i++) send_byte(8'($urandom_range(8'h20, 8'h7E)));
         end else if (kind < 45) begin
            send_byte(8'($urandom_range(0, 255)));
         end else if (kind < 55) begin
            case ($urandom_range(0, 3))
               0: send_byte(LF_CODE);
               1: send_byte(CR_CODE);
               2: send_byte(TAB_CODE);
               default: send_byte(BS_CODE);
            endcase
         end else if (kind < 75) begin
            n = $urandom_range(0, 10);
            if (n == 0) args.push_back(NO_ARG);
            for (i = 0; i < n; i++) args.push_back(pick_sgr_arg());
            send_csi(args, SGR_FINAL);
         end else if (kind < 82) begin
            args.push_back($urandom_range(0, 4) == 0 ? NO_ARG : $urandom_range(0, 3));
            send_csi(args, ED_FINAL);
         end else if (kind < 92) begin
            n = $urandom_range(1, 3);
            args.push_back($urandom_range(0, 4) == 0 ? NO_ARG : $urandom_range(0, 140));
            if (n > 1) args.push_back($urandom_range(0, 270));
            if (n > 2) args.push_back($urandom_range(0, 9));
            send_csi(args, CUP_FINAL);
         end else begin
            // broken sequences and stray finals
            send_byte(ESC_CODE);
            if ($urandom_range(0, 1)) begin
               send_byte(LBR_CODE);
               if ($urandom_range(0, 1)) send_number($urandom_range(0, 999));
            end
            send_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_plain_text();
      test_cursor_moves();
      test_attributes();
      test_erase_and_position();
      test_screen_sizes();
      test_backpressure();
      test_random_stream();
      wait_idle();
      if (error_count == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule
